>>> hw/rtl/hbi_pkg.sv
// Shared sizes, request and status codes, and table command type for the hash insert unit.
package hbi_pkg;

  localparam int NUM_BUCKETS      = 13;
  localparam int SLOTS_PER_BUCKET = 2;
  localparam int KEY_BITS         = 31;

  localparam int BKT_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int ROW_W     = SLOTS_PER_BUCKET * KEY_BITS;
  localparam int MOD_SHIFT = KEY_BITS + BKT_W;

  localparam logic [63:0] MOD_RECIP =
    ((64'd1 << MOD_SHIFT) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS);

  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_READ     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef struct packed {
    logic             rd_en;
    logic [BKT_W-1:0] rd_addr;
    logic             wr_en;
    logic [BKT_W-1:0] wr_addr;
    row_t             wr_data;
    logic             clr;
  } tbl_cmd_t;

endpackage

>>> hw/rtl/hbi_mod_unit.sv
// Residue unit: key modulo the bucket count by reciprocal multiplication.
module hbi_mod_unit
  import hbi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_BITS-1:0] key,
  output logic                done,
  output logic [BKT_W-1:0]    residue
);

  localparam int PROD_W = 2 * KEY_BITS + 1;

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] quo;
  logic [KEY_BITS-1:0] quo_next;
  logic                quo_vld;
  logic [PROD_W-1:0]   prod;
  logic [BKT_W-1:0]    residue_next;

  assign prod         = PROD_W'(key) * PROD_W'(MOD_RECIP[KEY_BITS:0]);
  assign quo_next     = KEY_BITS'(prod >> MOD_SHIFT);
  assign residue_next = BKT_W'(key_q - KEY_BITS'(quo * KEY_BITS'(NUM_BUCKETS)));

  always_ff @(posedge clk) begin
    if (rst) begin
      quo_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      quo_vld <= start;
      done    <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
      quo   <= quo_next;
    end
    if (quo_vld) begin
      residue <= residue_next;
    end
  end

endmodule

>>> hw/rtl/hbi_table.sv
// Bucket table: one row of slots per bucket, registered read, row valid bits for clearing.
module hbi_table
  import hbi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tbl_cmd_t cmd,
  output row_t     rd_row
);

  row_t                   mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] row_vld;
  row_t                   rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_vld_q <= row_vld[cmd.rd_addr];
      end
      if (cmd.clr) begin
        row_vld <= '0;
      end else if (cmd.wr_en) begin
        row_vld[cmd.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_vld_q ? rd_q : '0;

endmodule

>>> hw/rtl/bucketed_hash_insert_linear_probe_unit.sv
// Top level: request sequencer for the bucketed hash table with linear probing.
//
// Insert, read-slot and clear requests are taken one at a time; in_ready is high
// only while no request is in work, and a finished result waits in the output
// register while the next request is accepted; a result that finds the output
// register still occupied holds the sequencer until it drains. A nonzero insert
// takes its home bucket from a residue unit that multiplies the key by the
// reciprocal of the bucket count, then the table port reads one bucket row per
// cycle while the probe walks forward over the 13 buckets with wraparound. A read
// of a slot in range fetches the bucket row and then takes the slot from it; a
// read out of range, a clear, a zero key or an unused request code goes straight
// to the result. Clear empties the table by resetting every row valid bit.
// Duplicate keys are stored again.
module bucketed_hash_insert_linear_probe_unit
  import hbi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [30:0] key,
  input  logic [3:0]  read_bucket,
  input  logic [0:0]  read_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  placed_bucket,
  output logic [0:0]  placed_slot,
  output logic [30:0] read_value
);

  localparam int CNT_W = BKT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_FETCH = 6'b000100,
    S_PROBE = 6'b001000,
    S_RDOUT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state;
  logic [KEY_BITS-1:0] key_q;
  logic [BKT_W-1:0]    bucket;
  logic [BKT_W-1:0]    bkt_next;
  logic [SLOT_W-1:0]   rslot;
  logic [CNT_W-1:0]    cnt;
  logic                is_read;
  logic [1:0]          res_status;
  logic [3:0]          res_bucket;
  logic [0:0]          res_slot;
  logic [30:0]         res_value;

  logic                mod_start;
  logic                mod_done;
  logic [BKT_W-1:0]    mod_res;
  tbl_cmd_t            cmd;
  row_t                row;
  logic                found;
  logic [SLOT_W-1:0]   fslot;
  row_t                new_row;
  logic [KEY_BITS-1:0] rd_val;
  logic                rd_in_range;
  logic                out_free;

  assign in_ready    = (state == S_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign mod_start   = in_valid && in_ready && (req_type == REQ_INSERT) && (key != '0);
  assign bkt_next    = (bucket == BKT_W'(NUM_BUCKETS - 1)) ? '0 : bucket + 1'b1;
  assign rd_in_range = (int'(read_bucket) < NUM_BUCKETS) && (int'(read_slot) < SLOTS_PER_BUCKET);

  hbi_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .key     (KEY_BITS'(key)),
    .done    (mod_done),
    .residue (mod_res)
  );

  hbi_table u_table (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_row (row)
  );

  // First empty slot of the fetched row, the row with the key dropped in, and the value of the read slot.
  always_comb begin
    found   = 1'b0;
    fslot   = '0;
    new_row = row;
    rd_val  = '0;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (!found && (row[s*KEY_BITS +: KEY_BITS] == '0)) begin
        found = 1'b1;
        fslot = SLOT_W'(s);
      end
      if (SLOT_W'(s) == rslot) begin
        rd_val = row[s*KEY_BITS +: KEY_BITS];
      end
    end
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (SLOT_W'(s) == fslot) begin
        new_row[s*KEY_BITS +: KEY_BITS] = key_q;
      end
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.clr = in_valid && (req_type == REQ_CLEAR);
      end
      S_FETCH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = bucket;
      end
      S_PROBE: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = bkt_next;
        cmd.wr_en   = found;
        cmd.wr_addr = bucket;
        cmd.wr_data = new_row;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      is_read   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_q      <= KEY_BITS'(key);
            res_bucket <= '0;
            res_slot   <= '0;
            res_value  <= '0;
            case (req_type)
              REQ_INSERT: begin
                res_status <= ST_INSERTED;
                is_read    <= 1'b0;
                state      <= (key != '0) ? S_HASH : S_DONE;
              end
              REQ_READ: begin
                res_status <= ST_READ;
                if (rd_in_range) begin
                  bucket  <= BKT_W'(read_bucket);
                  rslot   <= SLOT_W'(read_slot);
                  is_read <= 1'b1;
                  state   <= S_FETCH;
                end else begin
                  is_read <= 1'b0;
                  state   <= S_DONE;
                end
              end
              REQ_CLEAR: begin
                res_status <= ST_CLEARED;
                is_read    <= 1'b0;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_INSERTED;
                is_read    <= 1'b0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_HASH: begin
          if (mod_done) begin
            bucket <= mod_res;
            state  <= S_FETCH;
          end
        end
        S_FETCH: begin
          cnt   <= '0;
          state <= is_read ? S_RDOUT : S_PROBE;
        end
        S_PROBE: begin
          if (found) begin
            res_bucket <= 4'(bucket);
            res_slot   <= fslot[0];
            state      <= S_DONE;
          end else if (cnt == CNT_W'(NUM_BUCKETS - 1)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            bucket <= bkt_next;
            cnt    <= cnt + 1'b1;
          end
        end
        S_RDOUT: begin
          res_value <= 31'(rd_val);
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            status        <= res_status;
            placed_bucket <= res_bucket;
            placed_slot   <= res_slot;
            read_value    <= res_value;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_home_range: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (int'(mod_res) < NUM_BUCKETS))
    else $error("home bucket out of range");

  a_placed_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_INSERTED)) |-> (int'(placed_bucket) < NUM_BUCKETS))
    else $error("placed bucket out of range");

  a_full_after_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && !found && cnt == CNT_W'(NUM_BUCKETS - 1))
      |=> (state == S_DONE && res_status == ST_FULL))
    else $error("full sweep did not report table full");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not moved to output register");

  a_probe_write_bucket: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (!cmd.clr && int'(cmd.wr_addr) < NUM_BUCKETS))
    else $error("bad table write");

endmodule
